>>> rtl/fpim_pkg.sv
`default_nettype none

package fpim_pkg;

  // field widths fixed by the interface
  localparam int ACT_WIDTH         = 8;
  localparam int WEIGHT_WIDTH      = 15;
  localparam int SUM_WIDTH         = 16;
  localparam int CFG_WIDTH         = 4;
  localparam int CFG_INDEX_WIDTH   = 2;
  localparam int ACC_WIDTH_DEFAULT = 16;
  localparam int MANT_WIDTH        = 3;
  localparam int EXP_WIDTH         = 4;

  // hidden one of the fp8 mantissa
  localparam logic [MANT_WIDTH:0] HIDDEN_ONE = 4'(1 << 3);

  // register indexes on the configuration port
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_WEIGHT_PRECISION   = 2'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_REFERENCE_EXPONENT = 2'd1;

  // register reset values
  localparam logic [CFG_WIDTH-1:0] WEIGHT_PRECISION_RESET   = 4'd8;
  localparam logic [CFG_WIDTH-1:0] REFERENCE_EXPONENT_RESET = 4'd0;

  // alignment of one product against the reference exponent
  typedef struct packed {
    logic                 left;
    logic [EXP_WIDTH-1:0] amount;
  } fpim_shift_t;

endpackage

`default_nettype wire

>>> rtl/fpim_front.sv
`default_nettype none

// front end: holds the configuration, decodes the fp8 word and forms the
// signed product of mantissa and weight
module fpim_front #(
  parameter int ACC_WIDTH = fpim_pkg::ACC_WIDTH_DEFAULT
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 cfg_write,
  input  wire logic [fpim_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
  input  wire logic [fpim_pkg::CFG_WIDTH-1:0]       cfg_data,
  input  wire logic [fpim_pkg::ACT_WIDTH-1:0]       activation,
  input  wire logic [fpim_pkg::WEIGHT_WIDTH-1:0]    weight_bits,
  output      logic [ACC_WIDTH-1:0]                 product,
  output      fpim_pkg::fpim_shift_t                shift
);

  logic [fpim_pkg::CFG_WIDTH-1:0]    weight_precision;
  logic [fpim_pkg::CFG_WIDTH-1:0]    reference_exponent;
  logic [fpim_pkg::MANT_WIDTH:0]     mag;
  logic [fpim_pkg::EXP_WIDTH-1:0]    exponent;
  logic [fpim_pkg::WEIGHT_WIDTH-1:0] low_mask;
  logic                              weight_sign;
  logic [ACC_WIDTH-1:0]              weight_value;
  logic [ACC_WIDTH-1:0]              mul;
  logic [fpim_pkg::EXP_WIDTH:0]      diff;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      weight_precision   <= fpim_pkg::WEIGHT_PRECISION_RESET;
      reference_exponent <= fpim_pkg::REFERENCE_EXPONENT_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        fpim_pkg::REG_WEIGHT_PRECISION:   weight_precision   <= cfg_data;
        fpim_pkg::REG_REFERENCE_EXPONENT: reference_exponent <= cfg_data;
        default: ;
      endcase
    end
  end

  // field decode
  assign mag      = fpim_pkg::HIDDEN_ONE | {1'b0, activation[fpim_pkg::MANT_WIDTH-1:0]};
  assign exponent = activation[fpim_pkg::ACT_WIDTH-2 -: fpim_pkg::EXP_WIDTH];

  // sign-extend the low weight_precision bits of the weight
  assign low_mask    = ~({fpim_pkg::WEIGHT_WIDTH{1'b1}} << weight_precision);
  assign weight_sign = (weight_precision != '0) &&
                       weight_bits[4'(weight_precision - 4'd1)];
  assign weight_value = ACC_WIDTH'(weight_bits & low_mask) |
                        (weight_sign ? ({ACC_WIDTH{1'b1}} << weight_precision)
                                     : '0);

  // product modulo 2^ACC_WIDTH, negated for a negative activation
  assign mul     = ACC_WIDTH'(ACC_WIDTH'(mag) * weight_value);
  assign product = activation[fpim_pkg::ACT_WIDTH-1] ? ACC_WIDTH'(~mul + 1'b1) : mul;

  // shift direction and distance from exponent minus reference
  assign diff         = {1'b0, exponent} - {1'b0, reference_exponent};
  assign shift.left   = ~diff[fpim_pkg::EXP_WIDTH];
  assign shift.amount = diff[fpim_pkg::EXP_WIDTH] ?
                        fpim_pkg::EXP_WIDTH'(~diff[fpim_pkg::EXP_WIDTH-1:0] + 1'b1) :
                        diff[fpim_pkg::EXP_WIDTH-1:0];

endmodule

`default_nettype wire

>>> rtl/fpim_queue.sv
`default_nettype none

// two-entry queue between front and back
module fpim_queue #(
  parameter int DATA_WIDTH = fpim_pkg::ACC_WIDTH_DEFAULT
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  push,
  input  wire logic [DATA_WIDTH-1:0] push_data,
  input  wire logic                  pop,
  output      logic [DATA_WIDTH-1:0] head,
  output      logic                  empty,
  output      logic                  full
);

  logic [DATA_WIDTH-1:0] entry [2];
  logic                  wr_ptr;
  logic                  rd_ptr;
  logic [1:0]            count;

  assign empty = (count == 2'd0);
  assign full  = (count == 2'd2);
  assign head  = entry[rd_ptr];

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= push_data;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

>>> rtl/fpim_back.sv
`default_nettype none

// back end: aligns each product and adds it into the running sum, which is
// also the output register
module fpim_back #(
  parameter int ACC_WIDTH = fpim_pkg::ACC_WIDTH_DEFAULT
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          q_empty,
  input  wire logic [ACC_WIDTH-1:0]          q_product,
  input  wire fpim_pkg::fpim_shift_t         q_shift,
  output      logic                          q_pop,
  output      logic                          result_valid,
  input  wire logic                          out_ready,
  output      logic [fpim_pkg::SUM_WIDTH-1:0] sum
);

  logic [ACC_WIDTH-1:0] running_sum;
  logic [ACC_WIDTH-1:0] aligned;

  // take the next word once the output slot is free or being drained
  assign q_pop = ~q_empty & (~result_valid | out_ready);

  // left shift or arithmetic right shift
  assign aligned = q_shift.left ? ACC_WIDTH'(q_product << q_shift.amount) :
                   ACC_WIDTH'($signed(q_product) >>> q_shift.amount);

  // accumulator and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      running_sum  <= '0;
      result_valid <= 1'b0;
    end else begin
      if (q_pop) begin
        running_sum  <= running_sum + aligned;
        result_valid <= 1'b1;
      end else if (out_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  assign sum = running_sum[fpim_pkg::SUM_WIDTH-1:0];

endmodule

`default_nettype wire

>>> rtl/fp8_int_multiply_accumulate.sv
`default_nettype none

// Multiplies an fp8 activation (sign, 4-bit exponent, 3-bit mantissa with a
// hidden one) by a signed integer weight of weight_precision bits, aligns the
// product by exponent minus reference_exponent and adds it into an
// ACC_WIDTH-bit running sum; each accepted word returns the low 16 bits of
// the new sum. One word is taken per clock while in_ready is high: the front
// decodes and multiplies in the cycle it accepts a word, a two-entry queue
// holds it, and the back shifts it and registers the new sum; the sustained
// rate is one word per cycle while out_ready stays high. in_ready drops only
// when the queue is full. Configuration writes take effect at once and are
// meant to be made while no word is in flight.
module fp8_int_multiply_accumulate #(
  parameter int ACC_WIDTH = fpim_pkg::ACC_WIDTH_DEFAULT
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 cfg_write,
  input  wire logic [fpim_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
  input  wire logic [fpim_pkg::CFG_WIDTH-1:0]       cfg_data,
  input  wire logic                                 in_valid,
  output      logic                                 in_ready,
  input  wire logic [fpim_pkg::ACT_WIDTH-1:0]       activation,
  input  wire logic [fpim_pkg::WEIGHT_WIDTH-1:0]    weight_bits,
  output      logic                                 result_valid,
  input  wire logic                                 out_ready,
  output      logic signed [fpim_pkg::SUM_WIDTH-1:0] accumulated_sum
);

  localparam int QW = ACC_WIDTH + $bits(fpim_pkg::fpim_shift_t);

  logic [ACC_WIDTH-1:0]     f_product;
  fpim_pkg::fpim_shift_t    f_shift;
  logic [QW-1:0]            q_head;
  logic                     q_empty;
  logic                     q_full;
  logic                     q_pop;
  logic                     push;
  logic [fpim_pkg::SUM_WIDTH-1:0] sum;

  assign in_ready = ~q_full;
  assign push     = in_valid & in_ready;

  fpim_front #(.ACC_WIDTH(ACC_WIDTH)) u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .activation  (activation),
    .weight_bits (weight_bits),
    .product     (f_product),
    .shift       (f_shift)
  );

  fpim_queue #(.DATA_WIDTH(QW)) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data ({f_shift, f_product}),
    .pop       (q_pop),
    .head      (q_head),
    .empty     (q_empty),
    .full      (q_full)
  );

  fpim_back #(.ACC_WIDTH(ACC_WIDTH)) u_back (
    .clk          (clk),
    .rst          (rst),
    .q_empty      (q_empty),
    .q_product    (q_head[ACC_WIDTH-1:0]),
    .q_shift      (q_head[QW-1:ACC_WIDTH]),
    .q_pop        (q_pop),
    .result_valid (result_valid),
    .out_ready    (out_ready),
    .sum          (sum)
  );

  assign accumulated_sum = $signed(sum);

endmodule

`default_nettype wire

>>> rtl/fpim_checker.sv
`default_nettype none

// port-level checks for the multiply-accumulate block
module fpim_checker (
  input wire logic                                  clk,
  input wire logic                                  rst,
  input wire logic                                  in_valid,
  input wire logic                                  in_ready,
  input wire logic                                  result_valid,
  input wire logic                                  out_ready,
  input wire logic signed [fpim_pkg::SUM_WIDTH-1:0] accumulated_sum
);

  logic [2:0] in_flight;

  // words accepted but not yet delivered
  always_ff @(posedge clk) begin
    if (rst) begin
      in_flight <= 3'd0;
    end else begin
      in_flight <= in_flight + 3'(in_valid & in_ready) - 3'(result_valid & out_ready);
    end
  end

  // a stalled result holds its value
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !out_ready |=> result_valid && $stable(accumulated_sum))
    else $error("result changed while stalled");

  // never more words in flight than queue plus output slot
  a_capacity: assert property (@(posedge clk) disable iff (rst)
    in_flight <= 3'd3)
    else $error("too many words in flight");

  // a result is shown only for an accepted word
  a_no_invent: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> in_flight != 3'd0)
    else $error("result without an accepted word");

  // back-pressure only when the queue holds two words
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> in_flight >= 3'd2)
    else $error("input stalled with room in the queue");

endmodule

bind fp8_int_multiply_accumulate fpim_checker u_fpim_checker (
  .clk             (clk),
  .rst             (rst),
  .in_valid        (in_valid),
  .in_ready        (in_ready),
  .result_valid    (result_valid),
  .out_ready       (out_ready),
  .accumulated_sum (accumulated_sum)
);

`default_nettype wire
